[rtl/tbsa_pkg.sv]
// Shared types and constants for the three-level bitmap slot allocator.
// Holds the request/response transaction structs, operation and status codes.
// No dependencies.
package tbsa_pkg;

	localparam int WORD_BITS_DEF = 64;
	localparam int MAX_SLOTS_DEF = 262144;

	localparam int OP_W   = 2;
	localparam int STAT_W = 2;
	localparam int SLOT_W = 18;
	localparam int CNT_W  = 19;

	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
	localparam logic [OP_W-1:0] OP_REBUILD = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [STAT_W-1:0] ST_DOUBLE = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE  = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [SLOT_W-1:0] slot_index;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] granted_slot;
		logic [CNT_W-1:0]  slots_in_use;
	} resp_t;

endpackage

[rtl/tbsa_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds while the read enable is low. No dependencies.
module tbsa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

[rtl/three_level_bitmap_slot_allocator.sv]
// Three-level bitmap slot allocator; top word in flops, mid and leaf maps in tbsa_ram.
// Allocate: top search, mid read, then leaf read and write back.
// Free: two reciprocal-multiply digit stages, then one read/modify/write.
// Empty pool, out-of-range free and unused code are answered straight from idle.
// One transaction at a time; done pulses one cycle and start may follow in that cycle.
// Reset clears top map, count and pool_entries; stale RAM words are masked by parent bits.
module three_level_bitmap_slot_allocator #(
	parameter int WORD_BITS = tbsa_pkg::WORD_BITS_DEF,
	parameter int MAX_SLOTS = tbsa_pkg::MAX_SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  tbsa_pkg::req_t             request,
	output logic                       done,
	output tbsa_pkg::resp_t            response,
	input  logic                       cfg_we,
	input  logic [tbsa_pkg::CNT_W-1:0] cfg_wdata
);

	import tbsa_pkg::*;

	localparam int T_W        = $clog2(WORD_BITS);
	localparam int LI_W       = 2 * T_W;
	localparam int MID_DEPTH  = 1 << T_W;
	localparam int LEAF_DEPTH = 1 << LI_W;
	localparam int CUBE       = WORD_BITS * WORD_BITS * WORD_BITS;
	localparam int CAP        = (MAX_SLOTS < CUBE) ? MAX_SLOTS : CUBE;
	// floor(x / WORD_BITS) = (x * DIV_R) >> DIV_K, exact for x below 2^CNT_W
	localparam int DIV_K      = CNT_W + T_W;
	localparam int DIV_R      = ((1 << DIV_K) + WORD_BITS - 1) / WORD_BITS;
	localparam int R_W        = DIV_K - T_W + 2;
	localparam int P_W        = SLOT_W + R_W;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_A_MID   = 3'd1;
	localparam logic [2:0] S_A_LEAF  = 3'd2;
	localparam logic [2:0] S_F_DIV2  = 3'd3;
	localparam logic [2:0] S_F_DIV3  = 3'd4;
	localparam logic [2:0] S_F_UPD   = 3'd5;
	localparam logic [2:0] S_REBUILD = 3'd6;

	function automatic logic [T_W-1:0] lowest_idx(input logic [WORD_BITS-1:0] w);
		logic [T_W-1:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--)
			if (w[i])
				r = T_W'(i);
		return r;
	endfunction

	function automatic logic [WORD_BITS-1:0] low_ones(input logic [T_W:0] k);
		logic [WORD_BITS-1:0] r;
		for (int i = 0; i < WORD_BITS; i++)
			r[i] = ((T_W+1)'(i) < k);
		return r;
	endfunction

	function automatic logic [WORD_BITS-1:0] one_bit(input logic [T_W-1:0] idx);
		logic [WORD_BITS-1:0] r;
		for (int i = 0; i < WORD_BITS; i++)
			r[i] = (T_W'(i) == idx);
		return r;
	endfunction

	logic [2:0]           state_q, state_d;
	logic [WORD_BITS-1:0] top_q, top_d;
	logic [CNT_W-1:0]     used_q, used_d;
	logic [CNT_W-1:0]     pool_q;
	logic                 done_q, done_d;
	resp_t                resp_q, resp_d;

	logic [SLOT_W-1:0]    s_q;
	logic [LI_W-1:0]      q1_q;
	logic [T_W-1:0]       q2_q;
	logic [T_W-1:0]       t_q, m_q, l_q;
	logic [LI_W-1:0]      li_q;
	logic [CNT_W-1:0]     base_q;

	logic [CNT_W-1:0]     n_eff;
	logic [CNT_W-1:0]     used_inc, used_dec;
	logic [P_W-1:0]       q1_prod, q2_prod;
	logic [T_W-1:0]       l_calc, m_calc;

	logic                 mid_we, mid_re, leaf_we, leaf_re;
	logic [T_W-1:0]       mid_waddr, mid_raddr;
	logic [LI_W-1:0]      leaf_waddr, leaf_raddr;
	logic [WORD_BITS-1:0] mid_wdata, mid_rdata, leaf_wdata, leaf_rdata;

	logic [WORD_BITS-1:0] mid_word, leaf_word, leaf_clr, mid_clr, leaf_set, mid_set;
	logic [T_W-1:0]       top_lo, m_lo, l_lo;
	logic                 top_any, mid_any, leaf_any, leaf_bit;
	logic [CNT_W-1:0]     rb_left;
	logic [T_W:0]         rb_k;
	logic                 rb_run;

	tbsa_ram #(.WIDTH(WORD_BITS), .DEPTH(MID_DEPTH)) u_mid_ram (
		.clk   (clk),
		.we    (mid_we),
		.waddr (mid_waddr),
		.wdata (mid_wdata),
		.re    (mid_re),
		.raddr (mid_raddr),
		.rdata (mid_rdata)
	);

	tbsa_ram #(.WIDTH(WORD_BITS), .DEPTH(LEAF_DEPTH)) u_leaf_ram (
		.clk   (clk),
		.we    (leaf_we),
		.waddr (leaf_waddr),
		.wdata (leaf_wdata),
		.re    (leaf_re),
		.raddr (leaf_raddr),
		.rdata (leaf_rdata)
	);

	assign n_eff    = (pool_q > CNT_W'(CAP)) ? CNT_W'(CAP) : pool_q;
	assign used_inc = (used_q < CNT_W'(CAP)) ? used_q + CNT_W'(1) : used_q;
	assign used_dec = (used_q != '0) ? used_q - CNT_W'(1) : used_q;

	// digit split of the freed slot: slot = (t * W + m) * W + l
	assign q1_prod = P_W'(request.slot_index) * P_W'(DIV_R);
	assign q2_prod = P_W'(q1_q) * P_W'(DIV_R);
	assign l_calc  = T_W'(s_q - SLOT_W'(q1_q * WORD_BITS));
	assign m_calc  = T_W'(q1_q - LI_W'(q2_q * WORD_BITS));

	// a word whose parent bit is clear is empty, whatever the RAM holds
	assign top_lo    = lowest_idx(top_q);
	assign top_any   = |top_q;
	assign mid_word  = top_q[t_q] ? mid_rdata : '0;
	assign m_lo      = lowest_idx(mid_word);
	assign mid_any   = |mid_word;
	assign leaf_word = mid_word[m_q] ? leaf_rdata : '0;
	assign l_lo      = lowest_idx(leaf_word);
	assign leaf_any  = |leaf_word;
	assign leaf_clr  = leaf_word & ~one_bit(l_lo);
	assign mid_clr   = mid_word & ~one_bit(m_q);
	assign leaf_bit  = leaf_word[l_q];
	assign leaf_set  = leaf_word | one_bit(l_q);
	assign mid_set   = mid_word | one_bit(m_q);

	assign rb_run  = (base_q < n_eff);
	assign rb_left = n_eff - base_q;
	assign rb_k    = (rb_left >= CNT_W'(WORD_BITS)) ? (T_W+1)'(WORD_BITS) : rb_left[T_W:0];

	always_comb begin
		mid_re     = 1'b0;
		mid_raddr  = top_lo;
		leaf_re    = 1'b0;
		leaf_raddr = {t_q, m_lo};
		unique case (state_q)
			S_IDLE: begin
				mid_re = start && (request.operation == OP_ALLOC);
			end
			S_A_MID: begin
				leaf_re = 1'b1;
			end
			S_F_DIV3: begin
				mid_re     = 1'b1;
				mid_raddr  = q2_q;
				leaf_re    = 1'b1;
				leaf_raddr = {q2_q, m_calc};
			end
			default: begin
				mid_re  = 1'b0;
				leaf_re = 1'b0;
			end
		endcase
	end

	always_comb begin
		mid_we     = 1'b0;
		mid_waddr  = t_q;
		mid_wdata  = mid_set;
		leaf_we    = 1'b0;
		leaf_waddr = {t_q, m_q};
		leaf_wdata = leaf_set;
		unique case (state_q)
			S_A_LEAF: begin
				leaf_we    = leaf_any;
				leaf_wdata = leaf_clr;
				mid_we     = leaf_any && (leaf_clr == '0);
				mid_wdata  = mid_clr;
			end
			S_F_UPD: begin
				leaf_we = !leaf_bit;
				mid_we  = !leaf_bit;
			end
			S_REBUILD: begin
				// mid word grows one bit per leaf word; the last write stands
				leaf_we    = rb_run;
				leaf_wdata = low_ones(rb_k);
				mid_we     = rb_run;
				mid_wdata  = low_ones({1'b0, m_q} + (T_W+1)'(1));
			end
			default: begin
				mid_we  = 1'b0;
				leaf_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d             = state_q;
		done_d              = 1'b0;
		top_d               = top_q;
		used_d              = used_q;
		resp_d.status       = ST_OK;
		resp_d.granted_slot = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (request.operation)
						OP_ALLOC: begin
							if (top_any) begin
								state_d = S_A_MID;
							end else begin
								done_d        = 1'b1;
								resp_d.status = ST_EMPTY;
							end
						end
						OP_FREE: begin
							if ({1'b0, request.slot_index} >= n_eff) begin
								done_d        = 1'b1;
								resp_d.status = ST_RANGE;
							end else begin
								state_d = S_F_DIV2;
							end
						end
						OP_REBUILD: begin
							state_d = S_REBUILD;
							top_d   = '0;
							used_d  = '0;
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			S_A_MID: begin
				if (mid_any) begin
					state_d = S_A_LEAF;
				end else begin
					state_d       = S_IDLE;
					done_d        = 1'b1;
					resp_d.status = ST_EMPTY;
				end
			end
			S_A_LEAF: begin
				state_d = S_IDLE;
				done_d  = 1'b1;
				if (leaf_any) begin
					resp_d.granted_slot = SLOT_W'(li_q * WORD_BITS + l_lo);
					used_d              = used_inc;
					if ((leaf_clr == '0) && (mid_clr == '0))
						top_d = top_q & ~one_bit(t_q);
				end else begin
					resp_d.status = ST_EMPTY;
				end
			end
			S_F_DIV2: begin
				state_d = S_F_DIV3;
			end
			S_F_DIV3: begin
				state_d = S_F_UPD;
			end
			S_F_UPD: begin
				state_d = S_IDLE;
				done_d  = 1'b1;
				if (leaf_bit) begin
					resp_d.status = ST_DOUBLE;
				end else begin
					used_d = used_dec;
					top_d  = top_q | one_bit(t_q);
				end
			end
			S_REBUILD: begin
				if (rb_run) begin
					top_d = low_ones({1'b0, t_q} + (T_W+1)'(1));
				end else begin
					state_d = S_IDLE;
					done_d  = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		resp_d.slots_in_use = used_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			top_q   <= '0;
			used_q  <= '0;
			pool_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			top_q   <= top_d;
			used_q  <= used_d;
			done_q  <= done_d;
			if (cfg_we)
				pool_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		resp_q <= resp_d;
		unique case (state_q)
			S_IDLE: begin
				s_q    <= request.slot_index;
				q1_q   <= q1_prod[DIV_K +: LI_W];
				t_q    <= (request.operation == OP_REBUILD) ? '0 : top_lo;
				m_q    <= '0;
				base_q <= '0;
			end
			S_A_MID: begin
				m_q  <= m_lo;
				li_q <= LI_W'(t_q * WORD_BITS + m_lo);
			end
			S_F_DIV2: begin
				l_q  <= l_calc;
				q2_q <= q2_prod[DIV_K +: T_W];
			end
			S_F_DIV3: begin
				t_q <= q2_q;
				m_q <= m_calc;
			end
			S_REBUILD: begin
				if (rb_run) begin
					base_q <= base_q + CNT_W'(WORD_BITS);
					if (m_q == T_W'(WORD_BITS - 1)) begin
						m_q <= '0;
						t_q <= t_q + T_W'(1);
					end else begin
						m_q <= m_q + T_W'(1);
					end
				end
			end
			default: begin
				base_q <= base_q;
			end
		endcase
	end

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign response = resp_q;

endmodule

[bench/three_level_bitmap_slot_allocator_tb.sv]
// Testbench for three_level_bitmap_slot_allocator: a directed table, then random phases of
// allocate/free/rebuild traffic; typed table rows are checked against the table, all other
// responses against an in-bench bitmap predictor. Depends on tbsa_pkg and the allocator RTL only.
module three_level_bitmap_slot_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tbsa_pkg::*;

	localparam int WB           = 64;
	localparam int LEAF_COUNT   = WB * WB;
	localparam int CAPACITY     = 262144;
	localparam int SLOT_MAX     = CAPACITY - 1;
	localparam int ENTRIES_MAX  = 19'h7FFFF;
	localparam int RANDOM_ITEMS = 1100;
	localparam int STALL_LIMIT  = 20000;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct {
		bit                is_cfg;
		logic [CNT_W-1:0]  cfg_value;
		req_t              req;
		bit                typed;
		resp_t             resp;
	} stim_row_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	req_t             request;
	logic             done;
	resp_t            response;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	// Predictor state: free bitmaps, in-use count, pool register copy.
	logic [WB-1:0]    free_top;
	logic [WB-1:0]    free_mid [WB];
	logic [WB-1:0]    free_leaf [LEAF_COUNT];
	int               in_use_count;
	int               pool_cfg;

	resp_t            pending_responses[$];
	int               held_slots[$];
	int               mismatch_count;
	int               random_items;

	three_level_bitmap_slot_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.response  (response),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(string what, int want, int got);
		$display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
		mismatch_count++;
	endtask

	function automatic int lowest_free(logic [WB-1:0] w);
		int i;
		for (i = 0; i < WB; i++)
			if (w[i])
				return i;
		return WB;
	endfunction

	function automatic void clear_maps();
		int i;
		free_top = '0;
		for (i = 0; i < WB; i++)
			free_mid[i] = '0;
		for (i = 0; i < LEAF_COUNT; i++)
			free_leaf[i] = '0;
	endfunction

	function automatic int effective_pool();
		return (pool_cfg < CAPACITY) ? pool_cfg : CAPACITY;
	endfunction

	// Advance the bitmap state by one transaction and return its response.
	function automatic resp_t predict_transaction(req_t r);
		resp_t res;
		int t, m, l, li, s, b, k, eff;
		res = '0;
		eff = effective_pool();
		case (r.operation)
			OP_ALLOC: begin
				t = lowest_free(free_top);
				m = WB;
				l = WB;
				li = 0;
				if (t < WB)
					m = lowest_free(free_mid[t]);
				if (m < WB) begin
					li = t * WB + m;
					l = lowest_free(free_leaf[li]);
				end
				if (l >= WB) begin
					res.status = ST_EMPTY;
				end else begin
					res.granted_slot = SLOT_W'(li * WB + l);
					free_leaf[li][l] = 1'b0;
					if (free_leaf[li] == '0) begin
						free_mid[t][m] = 1'b0;
						if (free_mid[t] == '0)
							free_top[t] = 1'b0;
					end
					if (in_use_count < CAPACITY)
						in_use_count++;
				end
			end
			OP_FREE: begin
				s = int'(r.slot_index);
				if (s >= eff) begin
					res.status = ST_RANGE;
				end else begin
					li = s / WB;
					b = s % WB;
					if (free_leaf[li][b]) begin
						res.status = ST_DOUBLE;
					end else begin
						free_leaf[li][b] = 1'b1;
						free_mid[li / WB][li % WB] = 1'b1;
						free_top[li / WB] = 1'b1;
						if (in_use_count > 0)
							in_use_count--;
					end
				end
			end
			OP_REBUILD: begin
				clear_maps();
				for (li = 0; li < LEAF_COUNT && li * WB < eff; li++) begin
					k = eff - li * WB;
					free_leaf[li] = (k >= WB) ? '1 : ((64'd1 << k) - 64'd1);
					free_mid[li / WB][li % WB] = 1'b1;
					free_top[li / WB] = 1'b1;
				end
				in_use_count = 0;
			end
			default: ;
		endcase
		res.slots_in_use = CNT_W'(in_use_count);
		return res;
	endfunction

	// Hold start until the transaction is taken, then predict it.
	task automatic issue_request(input req_t r, output resp_t predicted);
		@(negedge clk);
		start <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = predict_transaction(r);
	endtask

	task automatic drain_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_pool_entries(int value);
		drain_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value[CNT_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		pool_cfg = value & ENTRIES_MAX;
	endtask

	task automatic send_random(req_t r);
		resp_t predicted;
		issue_request(r, predicted);
		pending_responses.push_back(predicted);
		if (r.operation == OP_REBUILD)
			held_slots.delete();
		else if (r.operation == OP_ALLOC && predicted.status == ST_OK)
			held_slots.push_back(int'(predicted.granted_slot));
		random_items++;
	endtask

	function automatic stim_row_t cfg_row(int value);
		stim_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.cfg_value = value[CNT_W-1:0];
		return row;
	endfunction

	function automatic stim_row_t req_row(logic [OP_W-1:0] op, int slot, bit typed,
			logic [STAT_W-1:0] st, int granted, int count);
		stim_row_t row;
		row = '{default: '0};
		row.req.operation = op;
		row.req.slot_index = slot[SLOT_W-1:0];
		row.typed = typed;
		row.resp.status = st;
		row.resp.granted_slot = granted[SLOT_W-1:0];
		row.resp.slots_in_use = count[CNT_W-1:0];
		return row;
	endfunction

	always @(posedge clk) begin : check_response
		resp_t want;
		if (arst_n && done) begin
			if (pending_responses.size() == 0) begin
				report_mismatch("unexpected response, pending count", 0, 1);
			end else begin
				want = pending_responses.pop_front();
				if (response.status !== want.status)
					report_mismatch("status", want.status, response.status);
				if (response.granted_slot !== want.granted_slot)
					report_mismatch("granted_slot", want.granted_slot, response.granted_slot);
				if (response.slots_in_use !== want.slots_in_use)
					report_mismatch("slots_in_use", want.slots_in_use, response.slots_in_use);
			end
		end
	end

	// End the run when nothing moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog expired at %0t", $time);
		$display("three_level_bitmap_slot_allocator_tb: FAIL");
		$finish;
	end

	initial begin : stimulus
		stim_row_t rows[$];
		req_t rq;
		resp_t predicted;
		int i, phase_kind, n_items, pick, eff;
		bit scatter, idle_on;

		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		clear_maps();
		in_use_count = 0;
		pool_cfg = 0;
		mismatch_count = 0;
		random_items = 0;

		// Empty pool after reset, ranges, unused code, small pool, double free,
		// count floor, register changed without rebuild, clamp above capacity.
		rows.push_back(req_row(OP_ALLOC,   0,        1, ST_EMPTY,  0, 0));
		rows.push_back(req_row(OP_FREE,    0,        1, ST_RANGE,  0, 0));
		rows.push_back(req_row(OP_FREE,    SLOT_MAX, 1, ST_RANGE,  0, 0));
		rows.push_back(req_row(OP_UNUSED,  SLOT_MAX, 1, ST_OK,     0, 0));
		rows.push_back(cfg_row(3));
		rows.push_back(req_row(OP_REBUILD, 0,        1, ST_OK,     0, 0));
		rows.push_back(req_row(OP_ALLOC,   0,        1, ST_OK,     0, 1));
		rows.push_back(req_row(OP_ALLOC,   0,        1, ST_OK,     1, 2));
		rows.push_back(req_row(OP_ALLOC,   SLOT_MAX, 1, ST_OK,     2, 3));
		rows.push_back(req_row(OP_ALLOC,   0,        1, ST_EMPTY,  0, 3));
		rows.push_back(req_row(OP_FREE,    1,        1, ST_OK,     0, 2));
		rows.push_back(req_row(OP_FREE,    1,        1, ST_DOUBLE, 0, 2));
		rows.push_back(req_row(OP_FREE,    3,        1, ST_RANGE,  0, 2));
		rows.push_back(cfg_row(200));
		rows.push_back(req_row(OP_FREE,    150,      0, ST_OK,     0, 0));
		rows.push_back(req_row(OP_FREE,    199,      0, ST_OK,     0, 0));
		rows.push_back(req_row(OP_FREE,    198,      0, ST_OK,     0, 0));
		rows.push_back(req_row(OP_ALLOC,   0,        0, ST_OK,     0, 0));
		rows.push_back(cfg_row(2));
		rows.push_back(req_row(OP_ALLOC,   0,        0, ST_OK,     0, 0));
		rows.push_back(req_row(OP_FREE,    150,      1, ST_RANGE,  0, 2));
		rows.push_back(cfg_row(ENTRIES_MAX));
		rows.push_back(req_row(OP_REBUILD, SLOT_MAX, 1, ST_OK,     0, 0));
		rows.push_back(req_row(OP_FREE,    SLOT_MAX, 1, ST_DOUBLE, 0, 0));
		rows.push_back(req_row(OP_ALLOC,   0,        1, ST_OK,     0, 1));
		rows.push_back(cfg_row(CAPACITY));
		rows.push_back(req_row(OP_FREE,    0,        1, ST_OK,     0, 0));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				write_pool_entries(rows[i].cfg_value);
			end else begin
				issue_request(rows[i].req, predicted);
				pending_responses.push_back(rows[i].typed ? rows[i].resp : predicted);
			end
		end

		while (random_items < RANDOM_ITEMS) begin
			phase_kind = $urandom_range(0, 19);
			scatter = (phase_kind >= 2 && phase_kind <= 5);
			if (phase_kind == 0)
				write_pool_entries(0);
			else if (phase_kind == 1)
				write_pool_entries($urandom_range(0, 1) ? CAPACITY :
					$urandom_range(CAPACITY, ENTRIES_MAX));
			else if (scatter)
				write_pool_entries($urandom_range(0, WB));
			else if (phase_kind <= 7)
				write_pool_entries($urandom_range(300, 6000));
			else
				write_pool_entries($urandom_range(1, 300));

			if (scatter || $urandom_range(0, 9) != 0) begin
				rq.operation = OP_REBUILD;
				rq.slot_index = SLOT_W'($urandom);
				send_random(rq);
			end
			// Widen the range without rebuild so frees land in far words at every level.
			if (scatter)
				write_pool_entries($urandom_range(LEAF_COUNT, CAPACITY));

			n_items = $urandom_range(40, 120);
			for (i = 0; i < n_items && random_items < RANDOM_ITEMS; i++) begin
				idle_on = !(random_items >= 300 && random_items < 550);
				if (idle_on && $urandom_range(0, 99) < 29) begin
					@(negedge clk);
					start <= 1'b0;
					repeat ($urandom_range(0, 5)) @(negedge clk);
				end
				eff = effective_pool();
				rq.slot_index = SLOT_W'($urandom);
				pick = $urandom_range(0, 99);
				if (pick < 3) begin
					rq.operation = OP_UNUSED;
				end else if (pick < 5) begin
					rq.operation = OP_REBUILD;
				end else if (pick < 50) begin
					rq.operation = OP_ALLOC;
				end else begin
					rq.operation = OP_FREE;
					pick = $urandom_range(0, 99);
					if (pick < 55 && held_slots.size() != 0) begin
						pick = $urandom_range(0, held_slots.size() - 1);
						rq.slot_index = SLOT_W'(held_slots[pick]);
						held_slots.delete(pick);
					end else if (pick < 80 && eff > 0) begin
						rq.slot_index = SLOT_W'($urandom_range(0, eff - 1));
					end else if (pick < 90 && eff <= SLOT_MAX) begin
						rq.slot_index = SLOT_W'($urandom_range(eff, SLOT_MAX));
					end
				end
				send_random(rq);
			end
		end

		drain_idle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("three_level_bitmap_slot_allocator_tb: PASS");
		else
			$display("three_level_bitmap_slot_allocator_tb: FAIL");
		$finish;
	end

endmodule
